FILE: src/mahd_pkg.sv
// Shared types, code constants and lookup tables for the MPEG audio header decoder.
`default_nettype none

package mahd_pkg;

	typedef enum logic [2:0] {
		ST_OK               = 3'd0,
		ST_BAD_VERSION      = 3'd1,
		ST_BAD_LAYER        = 3'd2,
		ST_BAD_BITRATE      = 3'd3,
		ST_FREE_BITRATE     = 3'd4,
		ST_BAD_RATE         = 3'd5,
		ST_BAD_EMPHASIS     = 3'd6,
		ST_MODE_NOT_ALLOWED = 3'd7
	} status_t;

	localparam logic [2:0] ALLOC_A    = 3'd0;
	localparam logic [2:0] ALLOC_B    = 3'd1;
	localparam logic [2:0] ALLOC_C    = 3'd2;
	localparam logic [2:0] ALLOC_D    = 3'd3;
	localparam logic [2:0] ALLOC_LSF  = 3'd4;
	localparam logic [2:0] ALLOC_NONE = 3'd5;

	localparam logic [1:0] VER_MPEG25 = 2'd0;
	localparam logic [1:0] VER_RESVD  = 2'd1;
	localparam logic [1:0] VER_MPEG1  = 2'd3;

	localparam logic [1:0] LAYER_I   = 2'd0;
	localparam logic [1:0] LAYER_II  = 2'd1;
	localparam logic [1:0] LAYER_III = 2'd2;

	localparam logic [1:0] MODE_SINGLE   = 2'd3;
	localparam logic [1:0] EMPH_RESVD    = 2'd2;
	localparam logic [3:0] BR_IDX_BAD    = 4'hF;
	localparam logic [1:0] SR_IDX_BAD    = 2'd3;

	// Widths of the frame length datapath.
	localparam int N_W         = 26;   // coef * kbps * 1000 stays below 2^26
	localparam int Q_W         = 12;   // quotient and frame length
	localparam int RECIP_W     = 14;
	localparam int RECIP_SHIFT = 26;
	localparam int COEF_W      = 18;

	// Truncated reciprocals: floor(2^26 / rate), so the estimate is q or q-1.
	localparam logic [RECIP_W-1:0] RC_8000  = RECIP_W'((1 << RECIP_SHIFT) / 8000);
	localparam logic [RECIP_W-1:0] RC_11025 = RECIP_W'((1 << RECIP_SHIFT) / 11025);
	localparam logic [RECIP_W-1:0] RC_12000 = RECIP_W'((1 << RECIP_SHIFT) / 12000);
	localparam logic [RECIP_W-1:0] RC_16000 = RECIP_W'((1 << RECIP_SHIFT) / 16000);
	localparam logic [RECIP_W-1:0] RC_22050 = RECIP_W'((1 << RECIP_SHIFT) / 22050);
	localparam logic [RECIP_W-1:0] RC_24000 = RECIP_W'((1 << RECIP_SHIFT) / 24000);
	localparam logic [RECIP_W-1:0] RC_32000 = RECIP_W'((1 << RECIP_SHIFT) / 32000);
	localparam logic [RECIP_W-1:0] RC_44100 = RECIP_W'((1 << RECIP_SHIFT) / 44100);
	localparam logic [RECIP_W-1:0] RC_48000 = RECIP_W'((1 << RECIP_SHIFT) / 48000);

	// coef * 1000 per layer
	localparam logic [COEF_W-1:0] COEF_L1     = COEF_W'(12000);
	localparam logic [COEF_W-1:0] COEF_L23    = COEF_W'(144000);
	localparam logic [COEF_W-1:0] COEF_L3_LSF = COEF_W'(72000);

	localparam logic [10:0] SPF_384  = 11'd384;
	localparam logic [10:0] SPF_576  = 11'd576;
	localparam logic [10:0] SPF_1152 = 11'd1152;

	localparam logic [8:0] KBPS_V1 [3][16] = '{
		'{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
		  9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
		'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
		  9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
		'{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
		  9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}
	};

	localparam logic [8:0] KBPS_LSF [3][16] = '{
		'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
		  9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
		'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
		  9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
		'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
		  9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
	};

	// bit0: allowed with two channels, bit1: allowed with a single channel
	localparam logic [1:0] MODE_OK [16] = '{
		2'd3, 2'd2, 2'd2, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3,
		2'd3, 2'd3, 2'd3, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0
	};

	// Decoded header as it travels from the front end to the length pipeline.
	typedef struct packed {
		status_t            status;
		logic [1:0]         version_code;
		logic [1:0]         layer_index;
		logic [8:0]         bitrate_kbps;
		logic [15:0]        sample_rate_hz;
		logic [10:0]        samples_per_frame;
		logic [1:0]         channel_mode;
		logic [1:0]         mode_extension;
		logic [4:0]         header_flags;
		logic [1:0]         emphasis;
		logic [2:0]         alloc_table;
		logic [COEF_W-1:0]  coef_k;
		logic [RECIP_W-1:0] recip;
		logic               slot4;
	} hdr_t;

	function automatic logic [15:0] rate_lookup(input logic [1:0] ver, input logic [1:0] sr);
		logic [15:0] r;
		case ({ver, sr})
			4'b0000: r = 16'd11025;
			4'b0001: r = 16'd12000;
			4'b0010: r = 16'd8000;
			4'b1000: r = 16'd22050;
			4'b1001: r = 16'd24000;
			4'b1010: r = 16'd16000;
			4'b1100: r = 16'd44100;
			4'b1101: r = 16'd48000;
			4'b1110: r = 16'd32000;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

	function automatic logic [RECIP_W-1:0] recip_lookup(input logic [15:0] rate);
		logic [RECIP_W-1:0] rc;
		case (rate)
			16'd8000:  rc = RC_8000;
			16'd11025: rc = RC_11025;
			16'd12000: rc = RC_12000;
			16'd16000: rc = RC_16000;
			16'd22050: rc = RC_22050;
			16'd24000: rc = RC_24000;
			16'd32000: rc = RC_32000;
			16'd44100: rc = RC_44100;
			16'd48000: rc = RC_48000;
			default:   rc = '0;
		endcase
		return rc;
	endfunction

	function automatic logic [2:0] pick_table(input logic [8:0] per_chan,
		input logic [15:0] rate);
		logic [2:0] t;
		case (per_chan)
			9'd32, 9'd48:
				t = (rate == 16'd32000) ? ALLOC_D : ALLOC_C;
			9'd56, 9'd64, 9'd80:
				t = ALLOC_A;
			9'd96, 9'd112, 9'd128, 9'd160, 9'd192:
				t = (rate == 16'd48000) ? ALLOC_A : ALLOC_B;
			default:
				t = ALLOC_NONE;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

FILE: src/mpeg_audio_header_decode.sv
// Top level of the MPEG audio frame header decoder.
// Usage:
//   Input channel: header_word with in_valid/in_ready; one word is one frame header,
//   first header byte in bits 31..24. Output channel: one result word per header,
//   fields status .. frame_bytes with out_valid/out_ready.
//   A word is taken at a clock edge where valid and ready are both high.
// Throughput: one header per cycle, sustained, as long as the receiver takes results.
// Path: once its header is accepted, a result passes the queue and then the registered
//   product, quotient estimate, estimate times rate and correction into the output
//   register before it shows on the output.
// The frame length divide is a reciprocal multiply by a table constant for the
//   nine sample rates plus a single compare-and-increment correction.
// Stall: with a result waiting and out_ready low, the length pipeline freezes and the
//   queue in front of it keeps filling; in_ready drops only once the queue is full.
// Reset: arst_n low empties the queue and the pipeline; no result is pending after it.
`default_nettype none

module mpeg_audio_header_decode
	import mahd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] header_word,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [1:0]       version_code,
	output logic [1:0]       layer_index,
	output logic [8:0]       bitrate_kbps,
	output logic [15:0]      sample_rate_hz,
	output logic [10:0]      samples_per_frame,
	output logic [1:0]       channel_mode,
	output logic [1:0]       mode_extension,
	output logic [4:0]       header_flags,
	output logic [1:0]       emphasis,
	output logic [2:0]       alloc_table,
	output logic [11:0]      frame_bytes
);

	hdr_t           dec_hdr, q_hdr, res_hdr;
	logic           q_valid, back_ready;
	logic [Q_W-1:0] res_bytes;

	// Decode and check each header as it is offered.
	mahd_front u_front (
		.header_word (header_word),
		.hdr         (dec_hdr)
	);

	// Hold decoded headers while the length pipeline is stalled.
	mahd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_data  (dec_hdr),
		.pop_valid  (q_valid),
		.pop_ready  (back_ready),
		.pop_data   (q_hdr)
	);

	// Compute the frame length and present the result word.
	mahd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (back_ready),
		.in_hdr    (q_hdr),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_hdr   (res_hdr),
		.out_bytes (res_bytes)
	);

	// Unpack the result word onto its field ports.
	assign status            = res_hdr.status;
	assign version_code      = res_hdr.version_code;
	assign layer_index       = res_hdr.layer_index;
	assign bitrate_kbps      = res_hdr.bitrate_kbps;
	assign sample_rate_hz    = res_hdr.sample_rate_hz;
	assign samples_per_frame = res_hdr.samples_per_frame;
	assign channel_mode      = res_hdr.channel_mode;
	assign mode_extension    = res_hdr.mode_extension;
	assign header_flags      = res_hdr.header_flags;
	assign emphasis          = res_hdr.emphasis;
	assign alloc_table       = res_hdr.alloc_table;
	assign frame_bytes       = res_bytes;

endmodule

`default_nettype wire

FILE: src/mahd_front.sv
// Front end: splits a header word into fields, checks it and looks up its tables.
`default_nettype none

module mahd_front
	import mahd_pkg::*;
(
	input  wire logic [31:0] header_word,
	output hdr_t             hdr
);

	logic [1:0] ver, lay_code, sr, mode, mext, emph, lay;
	logic [3:0] br;
	logic       pad, priv, copy, orig, crc, lsf, single;
	logic [8:0] kbps, per_chan;
	logic [15:0] rate;
	status_t    status;
	logic [2:0] alloc;
	hdr_t       full;

	always_comb begin
		ver      = header_word[20:19];
		lay_code = header_word[18:17];
		crc      = ~header_word[16];
		br       = header_word[15:12];
		sr       = header_word[11:10];
		pad      = header_word[9];
		priv     = header_word[8];
		mode     = header_word[7:6];
		mext     = header_word[5:4];
		copy     = header_word[3];
		orig     = header_word[2];
		emph     = header_word[1:0];
		lsf      = (ver != VER_MPEG1);
		single   = (mode == MODE_SINGLE);
		lay      = (lay_code == 2'd0) ? LAYER_I : 2'd3 - lay_code;
		kbps     = lsf ? KBPS_LSF[lay][br] : KBPS_V1[lay][br];
		rate     = rate_lookup(ver, sr);
		per_chan = single ? kbps : {1'b0, kbps[8:1]};
	end

	// Checks run in status order; the first failure wins.
	always_comb begin
		status = ST_OK;
		alloc  = ALLOC_NONE;
		if (ver == VER_RESVD) begin
			status = ST_BAD_VERSION;
		end else if (lay_code == 2'd0) begin
			status = ST_BAD_LAYER;
		end else if (br == BR_IDX_BAD) begin
			status = ST_BAD_BITRATE;
		end else if (kbps == 9'd0) begin
			status = ST_FREE_BITRATE;
		end else if (sr == SR_IDX_BAD) begin
			status = ST_BAD_RATE;
		end else if (emph == EMPH_RESVD) begin
			status = ST_BAD_EMPHASIS;
		end else if (lay == LAYER_II && !lsf) begin
			if (!MODE_OK[br][single]) begin
				status = ST_MODE_NOT_ALLOWED;
			end else begin
				alloc = pick_table(per_chan, rate);
			end
		end else if (lay == LAYER_II) begin
			alloc = ALLOC_LSF;
		end
	end

	always_comb begin
		full.status            = status;
		full.version_code      = ver;
		full.layer_index       = lay;
		full.bitrate_kbps      = kbps;
		full.sample_rate_hz    = rate;
		full.channel_mode      = mode;
		full.mode_extension    = mext;
		full.header_flags      = {orig, copy, priv, pad, crc};
		full.emphasis          = emph;
		full.alloc_table       = alloc;
		full.recip             = recip_lookup(rate);
		full.slot4             = (lay == LAYER_I);
		case (lay)
			LAYER_I: begin
				full.coef_k            = COEF_L1;
				full.samples_per_frame = SPF_384;
			end
			LAYER_II: begin
				full.coef_k            = COEF_L23;
				full.samples_per_frame = SPF_1152;
			end
			default: begin
				full.coef_k            = lsf ? COEF_L3_LSF : COEF_L23;
				full.samples_per_frame = lsf ? SPF_576 : SPF_1152;
			end
		endcase
		// Zero every field of a rejected header but its status.
		if (status != ST_OK) begin
			hdr        = '0;
			hdr.status = status;
		end else begin
			hdr = full;
		end
	end

endmodule

`default_nettype wire

FILE: src/mahd_queue.sv
// Short FIFO of decoded headers between the front end and the length pipeline.
`default_nettype none

module mahd_queue
	import mahd_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  wire hdr_t push_data,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output hdr_t      pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	hdr_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

FILE: src/mahd_back.sv
// Back end: frame length by reciprocal multiply and correction, with the output register.
`default_nettype none

module mahd_back
	import mahd_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire hdr_t    in_hdr,
	output logic         out_valid,
	input  wire logic    out_ready,
	output hdr_t         out_hdr,
	output logic [Q_W-1:0] out_bytes
);

	logic                     en;
	logic                     v_s1, v_s2, v_s3, v_q;
	hdr_t                     hdr_s1, hdr_s2, hdr_s3, hdr_q;
	logic [N_W-1:0]           n_s1, n_s2, n_s3;
	logic [Q_W-1:0]           qe_s2, qe_s3, bytes_q;
	logic [N_W+2-1:0]         pr_s3;
	logic [N_W+RECIP_W-1:0]   prod;
	logic [N_W+COEF_W-1:0]    nfull;
	logic [N_W+2-1:0]         rem;
	logic [Q_W-1:0]           q, qp, bytes;

	// Advance the whole pipeline unless the output word is stalled.
	assign en        = !v_q || out_ready;
	assign in_ready  = en;
	assign out_valid = v_q;
	assign out_hdr   = hdr_q;
	assign out_bytes = bytes_q;

	always_comb begin
		nfull = (N_W + COEF_W)'(in_hdr.bitrate_kbps) * (N_W + COEF_W)'(in_hdr.coef_k);
		prod  = (N_W + RECIP_W)'(n_s1) * (N_W + RECIP_W)'(hdr_s1.recip);
		rem   = {2'b00, n_s3} - pr_s3;
		q     = qe_s3 + Q_W'(rem >= (N_W + 2)'(hdr_s3.sample_rate_hz));
		qp    = q + Q_W'(hdr_s3.header_flags[1]);
		bytes = hdr_s3.slot4 ? {qp[Q_W-3:0], 2'b00} : qp;
		if (hdr_s3.status != ST_OK) begin
			bytes = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_q  <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_q  <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hdr_s1  <= in_hdr;
			n_s1    <= nfull[N_W-1:0];
			hdr_s2  <= hdr_s1;
			n_s2    <= n_s1;
			qe_s2   <= prod[RECIP_SHIFT +: Q_W];
			hdr_s3  <= hdr_s2;
			n_s3    <= n_s2;
			qe_s3   <= qe_s2;
			pr_s3   <= (N_W + 2)'(qe_s2) * (N_W + 2)'(hdr_s2.sample_rate_hz);
			hdr_q   <= hdr_s3;
			bytes_q <= bytes;
		end
	end

endmodule

`default_nettype wire
